>>> rtl/rle8_pkg.sv
package rle8_pkg;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd256;
  localparam logic [16:0] BYTES_MAX       = 17'h1FFFF;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERRUN  = 2'd2
  } row_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [6:0]  pixel_count;
    logic        row_end;
    logic [1:0]  row_status;
    logic [16:0] row_bytes;
  } out_item_t;

endpackage

>>> rtl/rle8_row_decoder.sv
// Channel  | Direction | Ports                          | Moves
// ---------+-----------+--------------------------------+------------------------------
// in       | input     | in_valid, in_ready, in_data    | one compressed byte or end
// out      | output    | out_valid, out_ready, out_data | one run descriptor / row end
// cfg      | input     | cfg_valid, cfg_ready, cfg_data | row width write
//
// One request per cycle unless the output stalls: each byte is decoded in the cycle
// it is accepted and any result lands in the output register, so throughput is one
// byte per clock. out_valid rises in the cycle after a byte that yields a result.
// in_ready drops only while the output register holds a result that is not taken.
// Synchronous active-low reset: row width 256, decoder waits for a control byte.
module rle8_row_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rle8_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rle8_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import rle8_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  packet_left_r, packet_left_nxt;
  logic [15:0] pixels_left_r, pixels_left_nxt;
  logic        overrun_seen_r, overrun_seen_nxt;
  logic [16:0] byte_count_r, byte_count_nxt;
  logic [15:0] row_width_r, row_width_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_fire, cfg_fire;
  logic        res_fire, row_restart;
  logic [16:0] byte_inc;
  logic [15:0] pl_dec;
  logic [6:0]  pk_dec;
  logic [15:0] rep_cnt;
  logic        lit_ov;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign byte_inc = (byte_count_r == BYTES_MAX) ? byte_count_r : byte_count_r + 17'd1;
  assign pl_dec   = pixels_left_r - 16'd1;
  assign pk_dec   = (packet_left_r == 7'd0) ? 7'd0 : packet_left_r - 7'd1;
  assign rep_cnt  = {9'd0, packet_left_r};
  assign lit_ov   = (pixels_left_r == 16'd0);

  always_comb begin
    phase_nxt        = phase_r;
    packet_left_nxt  = packet_left_r;
    pixels_left_nxt  = pixels_left_r;
    overrun_seen_nxt = overrun_seen_r;
    byte_count_nxt   = byte_count_r;
    row_width_nxt    = row_width_r;
    res_fire         = 1'b0;
    row_restart      = 1'b0;
    out_data_nxt     = '0;

    if (in_fire) begin
      if (in_data.stream_end) begin
        res_fire               = 1'b1;
        row_restart            = 1'b1;
        out_data_nxt.row_end    = 1'b1;
        out_data_nxt.row_status = ST_SHORT;
        out_data_nxt.row_bytes  = byte_count_r;
      end else begin
        byte_count_nxt = byte_inc;
        unique case (phase_r)
          PH_LIT: begin
            res_fire                 = 1'b1;
            out_data_nxt.pixel_value = in_data.data_byte;
            out_data_nxt.pixel_count = 7'd1;
            pixels_left_nxt          = lit_ov ? 16'd0 : pl_dec;
            overrun_seen_nxt         = overrun_seen_r | lit_ov;
            packet_left_nxt          = pk_dec;
            if (pk_dec == 7'd0) begin
              if (pixels_left_nxt == 16'd0) begin
                row_restart             = 1'b1;
                out_data_nxt.row_end    = 1'b1;
                out_data_nxt.row_status = overrun_seen_nxt ? ST_OVERRUN : ST_COMPLETE;
                out_data_nxt.row_bytes  = byte_inc;
              end else begin
                phase_nxt = PH_CTRL;
              end
            end
          end
          PH_REP: begin
            res_fire                 = 1'b1;
            out_data_nxt.pixel_value = in_data.data_byte;
            out_data_nxt.pixel_count = packet_left_r;
            if (rep_cnt > pixels_left_r) begin
              overrun_seen_nxt = 1'b1;
              pixels_left_nxt  = 16'd0;
            end else begin
              pixels_left_nxt  = pixels_left_r - rep_cnt;
            end
            packet_left_nxt = 7'd0;
            phase_nxt       = PH_CTRL;
            if (pixels_left_nxt == 16'd0) begin
              row_restart             = 1'b1;
              out_data_nxt.row_end    = 1'b1;
              out_data_nxt.row_status = overrun_seen_nxt ? ST_OVERRUN : ST_COMPLETE;
              out_data_nxt.row_bytes  = byte_inc;
            end
          end
          default: begin
            // control byte; a zero count closes the row short
            if (in_data.data_byte[6:0] == 7'd0) begin
              res_fire                = 1'b1;
              row_restart             = 1'b1;
              out_data_nxt.row_end    = 1'b1;
              out_data_nxt.row_status = ST_SHORT;
              out_data_nxt.row_bytes  = byte_inc;
            end else begin
              packet_left_nxt = in_data.data_byte[6:0];
              phase_nxt       = in_data.data_byte[7] ? PH_LIT : PH_REP;
            end
          end
        endcase
      end
    end

    if (row_restart) begin
      phase_nxt        = PH_CTRL;
      packet_left_nxt  = 7'd0;
      pixels_left_nxt  = row_width_r;
      overrun_seen_nxt = 1'b0;
      byte_count_nxt   = 17'd0;
    end

    // width write before the row has consumed a byte also retargets the row
    if (cfg_fire) begin
      row_width_nxt = cfg_data;
      if (phase_r == PH_CTRL && byte_count_r == 17'd0) begin
        pixels_left_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_CTRL;
      packet_left_r  <= 7'd0;
      pixels_left_r  <= ROW_WIDTH_RESET;
      overrun_seen_r <= 1'b0;
      byte_count_r   <= 17'd0;
      row_width_r    <= ROW_WIDTH_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      packet_left_r  <= packet_left_nxt;
      pixels_left_r  <= pixels_left_nxt;
      overrun_seen_r <= overrun_seen_nxt;
      byte_count_r   <= byte_count_nxt;
      row_width_r    <= row_width_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> bench/rle8_row_decoder_tb.sv
`timescale 1ns / 1ps

module rle8_row_decoder_tb;
  import rle8_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 3;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_WIDTH = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    in_item_t    item;
    logic [15:0] width;
  } req_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  rle8_row_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  req_t        req_q[$];
  out_item_t   runs_due[$];
  int unsigned mismatches = 0;
  int unsigned n_items    = 0;
  int unsigned cycles     = 0;
  logic [15:0] cur_width  = ROW_WIDTH_RESET;

  // decoder mirror
  phase_t      dec_phase;
  logic [6:0]  dec_pkt_left;
  logic [15:0] dec_pix_left;
  logic        dec_overrun;
  logic [16:0] dec_bytes;
  logic [15:0] dec_width;

  function automatic void restart_row();
    dec_phase    = PH_CTRL;
    dec_pkt_left = '0;
    dec_pix_left = dec_width;
    dec_overrun  = 1'b0;
    dec_bytes    = '0;
  endfunction

  function automatic out_item_t row_end_run(input logic [7:0] v, input logic [6:0] n,
                                            input row_status_t st);
    out_item_t run;
    run.pixel_value = v;
    run.pixel_count = n;
    run.row_end     = 1'b1;
    run.row_status  = st;
    run.row_bytes   = dec_bytes;
    restart_row();
    return run;
  endfunction

  // returns 1 when the byte produces a run descriptor or row end
  function automatic bit decode_byte(input in_item_t req, output out_item_t run);
    logic [6:0] cnt;
    run = '0;
    if (req.stream_end) begin
      run = row_end_run(8'd0, 7'd0, ST_SHORT);
      return 1'b1;
    end
    if (dec_bytes != BYTES_MAX) dec_bytes++;
    case (dec_phase)
      PH_LIT: begin
        if (dec_pix_left == 0) dec_overrun = 1'b1;
        else dec_pix_left--;
        if (dec_pkt_left != 0) dec_pkt_left--;
        if (dec_pkt_left == 0) begin
          if (dec_pix_left == 0) begin
            run = row_end_run(req.data_byte, 7'd1, dec_overrun ? ST_OVERRUN : ST_COMPLETE);
            return 1'b1;
          end
          dec_phase = PH_CTRL;
        end
        run.pixel_value = req.data_byte;
        run.pixel_count = 7'd1;
        return 1'b1;
      end
      PH_REP: begin
        cnt = dec_pkt_left;
        if ({9'd0, cnt} > dec_pix_left) begin
          dec_overrun  = 1'b1;
          dec_pix_left = '0;
        end else begin
          dec_pix_left = dec_pix_left - {9'd0, cnt};
        end
        dec_pkt_left = '0;
        if (dec_pix_left == 0) begin
          run = row_end_run(req.data_byte, cnt, dec_overrun ? ST_OVERRUN : ST_COMPLETE);
          return 1'b1;
        end
        dec_phase = PH_CTRL;
        run.pixel_value = req.data_byte;
        run.pixel_count = cnt;
        return 1'b1;
      end
      default: begin
        cnt = req.data_byte[6:0];
        if (cnt == 0) begin
          run = row_end_run(8'd0, 7'd0, ST_SHORT);
          return 1'b1;
        end
        dec_pkt_left = cnt;
        dec_phase    = req.data_byte[7] ? PH_LIT : PH_REP;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  int unsigned in_wait     = 0;
  int unsigned idle_cycles = 0;
  bit          in_quiet    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      cfg_valid   <= 1'b0;
      cfg_data    <= '0;
      in_wait     = 0;
      idle_cycles = 0;
    end else if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
      // request not taken yet: hold
    end else if (in_wait != 0) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      in_wait--;
    end else if (req_q.size() == 0) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else if (req_q[0].kind == REQ_BYTE) begin
      in_valid  <= 1'b1;
      in_data   <= req_q[0].item;
      cfg_valid <= 1'b0;
      void'(req_q.pop_front());
      if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
      in_wait = in_quiet ? 0 : $urandom_range(0, 3);
    end else begin
      // width write: drain the decoder first, then let it sit idle before writing
      in_valid <= 1'b0;
      if (in_valid || runs_due.size() != 0) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > SETTLE_CYCLES) begin
        cfg_valid   <= 1'b1;
        cfg_data    <= req_q[0].width;
        idle_cycles = 0;
        void'(req_q.pop_front());
        in_wait = in_quiet ? 0 : $urandom_range(0, 3);
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int unsigned out_wait  = 0;
  bit          out_quiet = 1'b0;
  out_item_t   want;
  out_item_t   made;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  = 0;
      runs_due.delete();
      dec_width = ROW_WIDTH_RESET;
      restart_row();
    end else begin
      if (out_valid && out_ready) begin
        if (runs_due.size() == 0) begin
          $error("unexpected result %p", out_data);
          mismatches++;
        end else begin
          want = runs_due.pop_front();
          if (out_data.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, got %0d", want.pixel_value, out_data.pixel_value);
            mismatches++;
          end
          if (out_data.pixel_count !== want.pixel_count) begin
            $error("pixel_count: expected %0d, got %0d", want.pixel_count, out_data.pixel_count);
            mismatches++;
          end
          if (out_data.row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, out_data.row_end);
            mismatches++;
          end
          if (out_data.row_status !== want.row_status) begin
            $error("row_status: expected %0d, got %0d", want.row_status, out_data.row_status);
            mismatches++;
          end
          if (out_data.row_bytes !== want.row_bytes) begin
            $error("row_bytes: expected %0d, got %0d", want.row_bytes, out_data.row_bytes);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 3);
      end else if (out_wait != 0) begin
        out_wait--;
      end
      out_ready <= (out_wait == 0);

      if (cfg_valid && cfg_ready) begin
        dec_width = cfg_data;
        // reload only if the current row has not consumed anything yet
        if (dec_phase == PH_CTRL && dec_bytes == 0) dec_pix_left = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, made)) runs_due.push_back(made);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_item(input logic se, input logic [7:0] b);
    req_t r;
    r.kind            = REQ_BYTE;
    r.item.data_byte  = b;
    r.item.stream_end = se;
    r.width           = '0;
    req_q.push_back(r);
    n_items++;
  endtask

  task automatic push_width(input logic [15:0] w);
    req_t r;
    r.kind  = REQ_WIDTH;
    r.item  = '0;
    r.width = w;
    req_q.push_back(r);
    cur_width = w;
  endtask

  // one row of well-formed packets; mostly fills the width, sometimes overruns
  // it or is cut by a zero count or end of stream
  task automatic gen_row(input int unsigned width);
    int unsigned left, cnt, cap, pkts, k;
    left = width;
    pkts = 0;
    forever begin
      if (pkts != 0 && left == 0) break;
      if (pkts >= 8 || $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1) push_item(1'b1, 8'($urandom_range(0, 255)));
        else push_item(1'b0, $urandom_range(0, 1) ? 8'h80 : 8'h00);
        break;
      end
      cap = (left > 127) ? 127 : left;
      if (cap > 8 && $urandom_range(0, 9) < 7) cap = 8;
      if (left < 127 && (left == 0 || $urandom_range(0, 7) == 0))
        cnt = $urandom_range(left + 1, (left + 8 > 127) ? 127 : left + 8);
      else
        cnt = $urandom_range(1, cap);
      if ($urandom_range(0, 1) == 1) begin
        push_item(1'b0, 8'h80 | cnt[7:0]);
        for (k = 0; k < cnt; k++) push_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        push_item(1'b0, cnt[7:0]);
        push_item(1'b0, 8'($urandom_range(0, 255)));
      end
      left = (cnt > left) ? 0 : left - cnt;
      pkts++;
    end
  endtask

  int unsigned next_cfg;
  int unsigned j;

  initial begin
    // empty row, then zero count with the literal flag set
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h80);
    // width 4: literals then a repeat that fills the row exactly
    push_width(16'd4);
    push_item(1'b0, 8'h82);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h02);
    push_item(1'b0, 8'h5A);
    // repeat run longer than the row
    push_item(1'b0, 8'h7F);
    push_item(1'b0, 8'h3C);
    // literal packet running past the row
    push_item(1'b0, 8'h85);
    for (j = 0; j < 5; j++) push_item(1'b0, 8'h11 << j);
    // width change mid-row leaves the current row alone
    push_item(1'b0, 8'h81);
    push_width(16'd1);
    push_item(1'b0, 8'hC3);
    push_item(1'b1, 8'h00);
    // stream end inside literal and repeat packets
    push_item(1'b0, 8'h82);
    push_item(1'b0, 8'h11);
    push_item(1'b1, 8'h55);
    push_item(1'b0, 8'h03);
    push_item(1'b1, 8'hAA);
    // width 1 completes on one pixel
    push_item(1'b0, 8'h81);
    push_item(1'b0, 8'hFE);
    // width 0: any pixel is overrun, zero count still ends short
    push_width(16'd0);
    push_item(1'b0, 8'h01);
    push_item(1'b0, 8'h22);
    push_item(1'b0, 8'h00);

    next_cfg = n_items;
    while (n_items < 590) begin
      if (n_items >= next_cfg) begin
        case ($urandom_range(0, 5))
          0:       push_width(16'd1);
          1:       push_width(16'hFFFF);
          2:       push_width(16'($urandom_range(2, 8)));
          3:       push_width(16'($urandom_range(1, 64)));
          4:       push_width(16'($urandom_range(65, 400)));
          default: push_width(16'($urandom_range(1, 65535)));
        endcase
        next_cfg = n_items + $urandom_range(40, 120);
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: arbitrary bytes, occasional end of stream
        for (j = $urandom_range(1, 6); j != 0; j--)
          push_item($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
      end else begin
        gen_row(cur_width);
      end
    end
    push_item(1'b1, 8'($urandom_range(0, 255)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid || cfg_valid || runs_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
